### design/cfnl_pkg.sv
// Shared types and constants for the class file name locator.
package cfnl_pkg;

   // Widest pool slot number: a pool of 65536 entries plus a trailing wide entry.
   localparam int SLOT_W      = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Constant pool tags.
   localparam logic [7:0] TAG_UTF8      = 8'd1;
   localparam logic [7:0] TAG_INTEGER   = 8'd3;
   localparam logic [7:0] TAG_FLOAT     = 8'd4;
   localparam logic [7:0] TAG_LONG      = 8'd5;
   localparam logic [7:0] TAG_DOUBLE    = 8'd6;
   localparam logic [7:0] TAG_CLASS     = 8'd7;
   localparam logic [7:0] TAG_STRING    = 8'd8;
   localparam logic [7:0] TAG_FIELDREF  = 8'd9;
   localparam logic [7:0] TAG_METHODREF = 8'd10;
   localparam logic [7:0] TAG_IMETHREF  = 8'd11;
   localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

   // Result status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_LONG    = 3'd1;
   localparam logic [2:0] ST_UNKNOWN_TAG = 3'd2;
   localparam logic [2:0] ST_BAD_INDEX   = 3'd3;
   localparam logic [2:0] ST_TRUNCATED   = 3'd4;
   localparam logic [2:0] ST_POOL_LARGE  = 3'd5;

   // Trailer byte count.
   localparam logic [15:0] TAIL_BYTES = 16'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TAG,
      PH_BODY,
      PH_ULEN_HI,
      PH_ULEN_LO,
      PH_USKIP,
      PH_TAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ_CLS,
      BK_CHK_CLS,
      BK_READ_NAME,
      BK_CHK_NAME
   } back_state_type;

   // A job handed from the parser to the lookup engine.
   typedef struct packed {
      logic              lookup;
      logic [2:0]        status;
      logic [15:0]       cls;
      logic [SLOT_W-1:0] slot;
   } job_type;

   // Table write from the parser.
   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [3:0]  tag;
      logic [15:0] word;
      logic [31:0] off;
   } tab_wr_type;

   // Body length of a fixed-size entry by its tag.
   function automatic logic [15:0] body_len(input logic [3:0] tag);
      logic [15:0] len;
      len = 16'd4;
      if (tag == TAG_CLASS[3:0] || tag == TAG_STRING[3:0]) len = 16'd2;
      if (tag == TAG_LONG[3:0] || tag == TAG_DOUBLE[3:0]) len = 16'd8;
      return len;
   endfunction

endpackage

### design/cfnl_queue.sv
// Short job queue between the parser and the lookup engine.
module cfnl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfnl_pkg::job_type push_job,
   input  logic             pop,
   output cfnl_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   cfnl_pkg::job_type slots_ff [cfnl_pkg::QUEUE_DEPTH];
   logic [cfnl_pkg::QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [cfnl_pkg::QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [cfnl_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (cfnl_pkg::QUEUE_AW + 1)'(cfnl_pkg::QUEUE_DEPTH));
   assign head_job = slots_ff[rptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wptr_in  = wptr_ff + (cfnl_pkg::QUEUE_AW)'(push);
      rptr_in  = rptr_ff + (cfnl_pkg::QUEUE_AW)'(pop);
      count_in = count_ff + (cfnl_pkg::QUEUE_AW + 1)'(push) - (cfnl_pkg::QUEUE_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full || pop)
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("job queue count did not advance");
`endif

endmodule

### design/cfnl_front.sv
// Byte parser: walks the header and constant pool, fills the table, issues jobs.
module cfnl_front #(
   parameter int POOL_DEPTH  = 4096,
   parameter int OFFSET_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic                q_full,
   output logic                push,
   output cfnl_pkg::job_type    push_job,
   output cfnl_pkg::tab_wr_type tab_wr,
   input  logic                lookup_done
);

   localparam int SW = cfnl_pkg::SLOT_W;

   cfnl_pkg::phase_type       phase_ff, phase_in;
   logic [OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic [15:0]               remain_ff, remain_in;
   logic [SW-1:0]             slot_ff, slot_in;
   logic [15:0]               skip_ff, skip_in;
   logic [3:0]                tag_ff, tag_in;
   logic [15:0]               word_ff, word_in;
   logic [OFFSET_BITS-1:0]    off_ff, off_in;
   logic                      given_ff, given_in;
   logic                      phantom_ff, phantom_in;
   logic [15:0]               phantom_addr_ff, phantom_addr_in;
   logic [2:0]                lkp_cnt_ff, lkp_cnt_in;

   logic        accept;
   logic        writing_phase;
   logic        fin;
   logic        emit;
   logic [2:0]  emit_status;
   logic [15:0] count;
   logic [15:0] blen;
   logic [1:0]  adv;

   // Hold the byte stream off while the job queue is full or while a lookup still needs the table intact.
   always_comb begin
      writing_phase = (phase_ff == cfnl_pkg::PH_TAG) || (phase_ff == cfnl_pkg::PH_BODY) ||
                      (phase_ff == cfnl_pkg::PH_ULEN_HI) || (phase_ff == cfnl_pkg::PH_ULEN_LO) ||
                      (phase_ff == cfnl_pkg::PH_USKIP);
      req_stall = q_full || ((lkp_cnt_ff != '0) && writing_phase);
      accept    = req_valid && !req_stall;
      count     = {word_ff[15:8], req_data_byte};
      blen      = cfnl_pkg::body_len(tag_ff);
   end

   // Per-word parse step.
   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      remain_in       = remain_ff;
      slot_in         = slot_ff;
      skip_in         = skip_ff;
      tag_in          = tag_ff;
      word_in         = word_ff;
      off_in          = off_ff;
      given_in        = given_ff;
      phantom_in      = 1'b0;
      phantom_addr_in = phantom_addr_ff;
      push            = 1'b0;
      push_job        = '0;
      tab_wr          = '0;
      fin             = 1'b0;
      emit            = 1'b0;
      emit_status     = cfnl_pkg::ST_OK;
      adv             = 2'd1;

      // Second slot of a wide entry is written the cycle after the entry.
      if (phantom_ff) begin
         tab_wr.en   = 1'b1;
         tab_wr.addr = phantom_addr_ff;
      end

      if (accept) begin
         case (phase_ff)
            cfnl_pkg::PH_HEADER: begin
               if (pos_ff == OFFSET_BITS'(8)) begin
                  word_in = {req_data_byte, 8'd0};
               end else if (pos_ff == OFFSET_BITS'(9)) begin
                  if (17'(count) > 17'(POOL_DEPTH)) begin
                     emit        = 1'b1;
                     emit_status = cfnl_pkg::ST_POOL_LARGE;
                  end else begin
                     remain_in = (count != 16'd0) ? count - 16'd1 : 16'd0;
                     slot_in   = SW'(1);
                     if (remain_in == 16'd0) begin
                        phase_in = cfnl_pkg::PH_TAIL;
                        skip_in  = cfnl_pkg::TAIL_BYTES;
                     end else begin
                        phase_in = cfnl_pkg::PH_TAG;
                     end
                  end
               end
            end
            cfnl_pkg::PH_TAG: begin
               tag_in  = req_data_byte[3:0];
               word_in = 16'd0;
               off_in  = pos_ff;
               case (req_data_byte)
                  cfnl_pkg::TAG_CLASS, cfnl_pkg::TAG_STRING: begin
                     skip_in  = 16'd2;
                     phase_in = cfnl_pkg::PH_BODY;
                  end
                  cfnl_pkg::TAG_INTEGER, cfnl_pkg::TAG_FLOAT, cfnl_pkg::TAG_FIELDREF,
                  cfnl_pkg::TAG_METHODREF, cfnl_pkg::TAG_IMETHREF,
                  cfnl_pkg::TAG_NAMETYPE: begin
                     skip_in  = 16'd4;
                     phase_in = cfnl_pkg::PH_BODY;
                  end
                  cfnl_pkg::TAG_LONG, cfnl_pkg::TAG_DOUBLE: begin
                     skip_in  = 16'd8;
                     phase_in = cfnl_pkg::PH_BODY;
                  end
                  cfnl_pkg::TAG_UTF8: begin
                     phase_in = cfnl_pkg::PH_ULEN_HI;
                  end
                  default: begin
                     emit        = 1'b1;
                     emit_status = cfnl_pkg::ST_UNKNOWN_TAG;
                  end
               endcase
            end
            cfnl_pkg::PH_BODY: begin
               if (skip_ff == blen) begin
                  word_in = {req_data_byte, 8'd0};
               end else if (skip_ff == blen - 16'd1) begin
                  word_in = word_ff | {8'd0, req_data_byte};
               end
               skip_in = skip_ff - 16'd1;
               fin     = (skip_ff == 16'd1);
            end
            cfnl_pkg::PH_ULEN_HI: begin
               word_in  = {req_data_byte, 8'd0};
               phase_in = cfnl_pkg::PH_ULEN_LO;
            end
            cfnl_pkg::PH_ULEN_LO: begin
               word_in = word_ff | {8'd0, req_data_byte};
               skip_in = word_in;
               if (word_in == 16'd0) begin
                  fin = 1'b1;
               end else begin
                  phase_in = cfnl_pkg::PH_USKIP;
               end
            end
            cfnl_pkg::PH_USKIP: begin
               skip_in = skip_ff - 16'd1;
               fin     = (skip_ff == 16'd1);
            end
            cfnl_pkg::PH_TAIL: begin
               if (skip_ff == 16'd1) begin
                  word_in       = word_ff | {8'd0, req_data_byte};
                  push          = 1'b1;
                  push_job.lookup = 1'b1;
                  push_job.cls  = word_in;
                  push_job.slot = slot_ff;
                  given_in      = 1'b1;
                  phase_in      = cfnl_pkg::PH_DONE;
               end else begin
                  if (skip_ff == 16'd2) begin
                     word_in = {req_data_byte, 8'd0};
                  end
                  skip_in = skip_ff - 16'd1;
               end
            end
            default: begin
            end
         endcase

         // Entry complete: store it if its slot is in the table and step past its one or two slots.
         if (fin) begin
            if (tag_ff == cfnl_pkg::TAG_LONG[3:0] || tag_ff == cfnl_pkg::TAG_DOUBLE[3:0]) begin
               adv = 2'd2;
            end
            if (slot_ff < SW'(POOL_DEPTH)) begin
               tab_wr.en   = 1'b1;
               tab_wr.addr = slot_ff[15:0];
               tab_wr.tag  = tag_ff;
               tab_wr.word = word_in;
               tab_wr.off  = 32'(off_ff);
            end
            if (adv == 2'd2 && (slot_ff + SW'(1)) < SW'(POOL_DEPTH)) begin
               phantom_in      = 1'b1;
               phantom_addr_in = 16'(slot_ff + SW'(1));
            end
            slot_in   = slot_ff + SW'(adv);
            remain_in = (remain_ff > 16'(adv)) ? remain_ff - 16'(adv) : 16'd0;
            if (remain_in == 16'd0) begin
               phase_in = cfnl_pkg::PH_TAIL;
               skip_in  = cfnl_pkg::TAIL_BYTES;
            end else begin
               phase_in = cfnl_pkg::PH_TAG;
            end
         end

         // Immediate status result.
         if (emit) begin
            push            = 1'b1;
            push_job.status = emit_status;
            given_in        = 1'b1;
            phase_in        = cfnl_pkg::PH_DONE;
         end

         pos_in = pos_ff + OFFSET_BITS'(1);

         // End of file: report truncation if no result was given, and start over.
         if (req_last) begin
            if (!given_in) begin
               push            = 1'b1;
               push_job        = '0;
               push_job.status = cfnl_pkg::ST_TRUNCATED;
            end
            phase_in  = cfnl_pkg::PH_HEADER;
            pos_in    = '0;
            remain_in = '0;
            slot_in   = '0;
            skip_in   = '0;
            tag_in    = '0;
            word_in   = '0;
            given_in  = 1'b0;
         end
      end

      lkp_cnt_in = lkp_cnt_ff + 3'(push && push_job.lookup) - 3'(lookup_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cfnl_pkg::PH_HEADER;
         pos_ff     <= '0;
         remain_ff  <= '0;
         slot_ff    <= '0;
         skip_ff    <= '0;
         tag_ff     <= '0;
         word_ff    <= '0;
         given_ff   <= 1'b0;
         phantom_ff <= 1'b0;
         lkp_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         remain_ff  <= remain_in;
         slot_ff    <= slot_in;
         skip_ff    <= skip_in;
         tag_ff     <= tag_in;
         word_ff    <= word_in;
         given_ff   <= given_in;
         phantom_ff <= phantom_in;
         lkp_cnt_ff <= lkp_cnt_in;
      end
   end

   // Entry offset and wide-entry address need no reset.
   always_ff @(posedge clock) begin
      off_ff          <= off_in;
      phantom_addr_ff <= phantom_addr_in;
   end

endmodule

### design/cfnl_back.sv
// Lookup engine: owns the entry table, resolves this_class and drives the result word.
module cfnl_back #(
   parameter int POOL_DEPTH  = 4096,
   parameter int OFFSET_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  cfnl_pkg::tab_wr_type tab_wr,
   input  cfnl_pkg::job_type    head_job,
   input  logic                q_empty,
   output logic                pop,
   output logic                lookup_done,
   input  logic                csr_wr_en,
   input  logic [16:0]         csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [23:0]         rsp_name_offset,
   output logic [15:0]         rsp_name_length
);

   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int EW = 20 + OFFSET_BITS;
   localparam int SW = cfnl_pkg::SLOT_W;

   logic [EW-1:0] mem [POOL_DEPTH];

   cfnl_pkg::back_state_type state_ff, state_in;
   logic [15:0]      cls_ff, cls_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [15:0]      ni_ff, ni_in;
   logic [EW-1:0]    rd_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [16:0]      max_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [23:0]      offset_ff, offset_in;
   logic [15:0]      length_ff, length_in;

   logic             out_free;
   logic             load;
   logic [3:0]       rd_tag;
   logic [15:0]      rd_word;
   logic [OFFSET_BITS-1:0] rd_off;
   logic [OFFSET_BITS-1:0] name_off;
   logic [31:0]      name_off_wide;
   logic             cls_ok;
   logic             name_ok;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_name_offset = offset_ff;
   assign rsp_name_length = length_ff;

   // Decode the registered table read.
   always_comb begin
      rd_tag        = rd_ff[EW-1 -: 4];
      rd_word       = rd_ff[OFFSET_BITS +: 16];
      rd_off        = rd_ff[OFFSET_BITS-1:0];
      name_off      = rd_off + OFFSET_BITS'(3);
      name_off_wide = 32'(name_off);
      cls_ok  = (cls_ff != 16'd0) && (SW'(cls_ff) < slot_ff) &&
                (17'(cls_ff) < 17'(POOL_DEPTH)) && (rd_tag == cfnl_pkg::TAG_CLASS[3:0]);
      name_ok = (ni_ff != 16'd0) && (SW'(ni_ff) < slot_ff) &&
                (17'(ni_ff) < 17'(POOL_DEPTH)) && (rd_tag == cfnl_pkg::TAG_UTF8[3:0]);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfnl_pkg::BK_IDLE: begin
            if (!q_empty && head_job.lookup) state_in = cfnl_pkg::BK_READ_CLS;
         end
         cfnl_pkg::BK_READ_CLS: state_in = cfnl_pkg::BK_CHK_CLS;
         cfnl_pkg::BK_CHK_CLS: begin
            if (cls_ok) state_in = cfnl_pkg::BK_READ_NAME;
            else if (out_free) state_in = cfnl_pkg::BK_IDLE;
         end
         cfnl_pkg::BK_READ_NAME: state_in = cfnl_pkg::BK_CHK_NAME;
         cfnl_pkg::BK_CHK_NAME: begin
            if (out_free) state_in = cfnl_pkg::BK_IDLE;
         end
         default: state_in = cfnl_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop         = 1'b0;
      load        = 1'b0;
      lookup_done = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = cls_ff[AW-1:0];
      cls_in      = cls_ff;
      slot_in     = slot_ff;
      ni_in       = ni_ff;
      status_in   = status_ff;
      offset_in   = offset_ff;
      length_in   = length_ff;
      unique case (state_ff)
         cfnl_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (head_job.lookup) begin
                  pop     = 1'b1;
                  cls_in  = head_job.cls;
                  slot_in = head_job.slot;
               end else if (out_free) begin
                  pop       = 1'b1;
                  load      = 1'b1;
                  status_in = head_job.status;
                  offset_in = '0;
                  length_in = '0;
               end
            end
         end
         cfnl_pkg::BK_READ_CLS: begin
            rd_en = 1'b1;
         end
         cfnl_pkg::BK_CHK_CLS: begin
            if (cls_ok) begin
               ni_in = rd_word;
            end else if (out_free) begin
               load        = 1'b1;
               lookup_done = 1'b1;
               status_in   = cfnl_pkg::ST_BAD_INDEX;
               offset_in   = '0;
               length_in   = '0;
            end
         end
         cfnl_pkg::BK_READ_NAME: begin
            rd_en   = 1'b1;
            rd_addr = ni_ff[AW-1:0];
         end
         cfnl_pkg::BK_CHK_NAME: begin
            if (out_free) begin
               load        = 1'b1;
               lookup_done = 1'b1;
               if (!name_ok) begin
                  status_in = cfnl_pkg::ST_BAD_INDEX;
                  offset_in = '0;
                  length_in = '0;
               end else begin
                  status_in = ((17'(rd_word) + 17'd1) > max_ff) ? cfnl_pkg::ST_TOO_LONG
                                                                : cfnl_pkg::ST_OK;
                  offset_in = name_off_wide[23:0];
                  length_in = rd_word;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfnl_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= 17'd2048;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff    <= cls_in;
      slot_ff   <= slot_in;
      ni_ff     <= ni_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      length_ff <= length_in;
   end

   // Entry table: one write port from the parser, one registered read port.
   always_ff @(posedge clock) begin
      if (tab_wr.en) begin
         mem[tab_wr.addr[AW-1:0]] <= {tab_wr.tag, tab_wr.word, tab_wr.off[OFFSET_BITS-1:0]};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

`ifndef NO_ASSERTIONS
   a_no_write_during_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cfnl_pkg::BK_IDLE) |-> !tab_wr.en)
      else $error("table written while a lookup is in flight");
   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      lookup_done |=> rsp_valid_ff)
      else $error("finished lookup produced no result word");
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("result word overwritten while stalled");
`endif

endmodule

### design/class_file_name_locator.sv
// Top level of the class file name locator.
//
// The req_ channel carries one word per accepted cycle: a class file byte and a
// flag marking the final byte of the file. Bytes are accepted back to back, one
// per cycle unless stalled, while parsing the header and the constant pool. The
// rsp_ channel gives at most one word per file: a status and, on success or an
// overlong name, the file offset and length of the class name string. The
// parser fills an entry table as it walks the pool; once this_class has
// arrived, a job goes through a four-entry queue to the lookup engine, which
// reads the table up to twice through its single read port, in the states
// read class, check class, read name and check name; a bad class index ends
// the lookup at the class check. While a lookup is in flight, the parser
// stalls only when the next file's pool walk reaches the table. A stalled
// result word holds in its output register; once the job queue is full the
// input stalls too.
// Reset clears all parse state and sets max_name_size to 2048; the table
// contents are not cleared and need no clearing pass. csr_wr_en writes
// max_name_size; write it only while the block is idle.
module class_file_name_locator #(
   parameter int POOL_DEPTH  = 4096,
   parameter int OFFSET_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [23:0] rsp_name_offset,
   output logic [15:0] rsp_name_length,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   logic                 lookup_done;
   cfnl_pkg::job_type    push_job;
   cfnl_pkg::job_type    head_job;
   cfnl_pkg::tab_wr_type tab_wr;

   cfnl_front #(
      .POOL_DEPTH  (POOL_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job),
      .tab_wr        (tab_wr),
      .lookup_done   (lookup_done)
   );

   cfnl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   cfnl_back #(
      .POOL_DEPTH  (POOL_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .tab_wr          (tab_wr),
      .head_job        (head_job),
      .q_empty         (q_empty),
      .pop             (pop),
      .lookup_done     (lookup_done),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_name_offset (rsp_name_offset),
      .rsp_name_length (rsp_name_length)
   );

endmodule

### dv/class_file_name_locator_tb.sv
// Testbench for the class file name locator: streams class files and checks each result.
`timescale 1ns / 1ps

module class_file_name_locator_tb;

   localparam int POOL     = 4096;
   localparam int QUIET_MAX = 500;
   localparam int SETTLE   = 12;

   typedef struct {
      logic [2:0]  status;
      logic [23:0] offset;
      logic [15:0] length;
   } name_result_type;

   typedef struct {
      logic [7:0]  data;
      bit          last;
      bit          typed;
      logic [2:0]  status;
      logic [23:0] offset;
      logic [15:0] length;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [23:0] rsp_name_offset;
   logic [15:0] rsp_name_length;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   class_file_name_locator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_name_offset (rsp_name_offset),
      .rsp_name_length (rsp_name_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Parser mirror: walk state, entry table and the name buffer limit.
   logic [16:0]         buf_limit;
   logic [23:0]         file_pos;
   cfnl_pkg::phase_type walk_phase;
   int          slots_left;
   int          next_slot;
   int          skip_left;
   int          body_bytes;
   logic [3:0]  entry_tag;
   logic [15:0] word_acc;
   bit          name_done;
   logic [7:0]  pool_tag  [POOL];
   logic [15:0] pool_word [POOL];
   logic [23:0] pool_off  [POOL];
   bit              hit;
   name_result_type hit_val;

   name_result_type name_q[$];
   name_result_type want;
   logic [7:0]      img[$];
   dir_row_type     dir_rows[23];
   int  errors;
   int  bytes_sent;
   bit  calm;
   int  stall_left;
   int  stall_draw;
   int  quiet;

   task automatic report(input string what);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic clear_walk();
      file_pos   = '0;
      walk_phase = cfnl_pkg::PH_HEADER;
      slots_left = 0;
      next_slot  = 0;
      skip_left  = 0;
      body_bytes = 0;
      entry_tag  = '0;
      word_acc   = '0;
      name_done  = 0;
   endtask

   task automatic give_result(input logic [2:0] st, input logic [23:0] off,
                              input logic [15:0] len);
      hit        = 1;
      hit_val    = '{st, off, len};
      name_done  = 1;
      walk_phase = cfnl_pkg::PH_DONE;
   endtask

   // An entry is done: record its word, blank the second slot of a wide entry.
   task automatic close_entry();
      int adv;
      adv = (entry_tag == cfnl_pkg::TAG_LONG[3:0] ||
             entry_tag == cfnl_pkg::TAG_DOUBLE[3:0]) ? 2 : 1;
      if (next_slot < POOL) pool_word[next_slot] = word_acc;
      if (adv == 2 && next_slot + 1 < POOL) begin
         pool_tag[next_slot + 1]  = '0;
         pool_word[next_slot + 1] = '0;
         pool_off[next_slot + 1]  = '0;
      end
      next_slot += adv;
      slots_left = (slots_left > adv) ? slots_left - adv : 0;
      if (slots_left == 0) begin
         walk_phase = cfnl_pkg::PH_TAIL;
         skip_left  = 4;
      end else begin
         walk_phase = cfnl_pkg::PH_TAG;
      end
   endtask

   function automatic bit slot_has(input int idx, input logic [7:0] tg);
      return idx >= 1 && idx < next_slot && idx < POOL && pool_tag[idx] == tg;
   endfunction

   // Two lookups: this_class to a Class entry, its name index to a Utf8 entry.
   task automatic find_name(input logic [15:0] cls);
      int          ni;
      logic [15:0] len;
      logic [23:0] off;
      if (!slot_has(cls, cfnl_pkg::TAG_CLASS)) begin
         give_result(cfnl_pkg::ST_BAD_INDEX, '0, '0);
         return;
      end
      ni = pool_word[cls];
      if (!slot_has(ni, cfnl_pkg::TAG_UTF8)) begin
         give_result(cfnl_pkg::ST_BAD_INDEX, '0, '0);
         return;
      end
      len = pool_word[ni];
      off = pool_off[ni] + 24'd3;
      if (int'(len) + 1 > int'(buf_limit)) give_result(cfnl_pkg::ST_TOO_LONG, off, len);
      else give_result(cfnl_pkg::ST_OK, off, len);
   endtask

   // Advance the mirror by one accepted word; hit tells whether a result is due.
   task automatic parse_byte(input logic [7:0] b, input bit lst);
      int cnt;
      int k;
      hit = 0;
      case (walk_phase)
         cfnl_pkg::PH_HEADER: begin
            if (file_pos == 24'd8) begin
               word_acc = {b, 8'h00};
            end else if (file_pos == 24'd9) begin
               cnt = int'({word_acc[15:8], b});
               if (cnt > POOL) begin
                  give_result(cfnl_pkg::ST_POOL_LARGE, '0, '0);
               end else begin
                  slots_left = (cnt != 0) ? cnt - 1 : 0;
                  next_slot  = 1;
                  if (slots_left == 0) begin
                     walk_phase = cfnl_pkg::PH_TAIL;
                     skip_left  = 4;
                  end else begin
                     walk_phase = cfnl_pkg::PH_TAG;
                  end
               end
            end
         end
         cfnl_pkg::PH_TAG: begin
            entry_tag = b[3:0];
            word_acc  = '0;
            if (next_slot < POOL) begin
               pool_tag[next_slot] = b;
               pool_off[next_slot] = file_pos;
            end
            case (b)
               cfnl_pkg::TAG_CLASS, cfnl_pkg::TAG_STRING: begin
                  body_bytes = 2; skip_left = 2; walk_phase = cfnl_pkg::PH_BODY;
               end
               cfnl_pkg::TAG_FIELDREF, cfnl_pkg::TAG_METHODREF, cfnl_pkg::TAG_IMETHREF,
               cfnl_pkg::TAG_INTEGER, cfnl_pkg::TAG_FLOAT, cfnl_pkg::TAG_NAMETYPE: begin
                  body_bytes = 4; skip_left = 4; walk_phase = cfnl_pkg::PH_BODY;
               end
               cfnl_pkg::TAG_LONG, cfnl_pkg::TAG_DOUBLE: begin
                  body_bytes = 8; skip_left = 8; walk_phase = cfnl_pkg::PH_BODY;
               end
               cfnl_pkg::TAG_UTF8: walk_phase = cfnl_pkg::PH_ULEN_HI;
               default: give_result(cfnl_pkg::ST_UNKNOWN_TAG, '0, '0);
            endcase
         end
         cfnl_pkg::PH_BODY: begin
            k = body_bytes - skip_left;
            if (k == 0) word_acc = {b, 8'h00};
            else if (k == 1) word_acc[7:0] = b;
            skip_left--;
            if (skip_left == 0) close_entry();
         end
         cfnl_pkg::PH_ULEN_HI: begin
            word_acc   = {b, 8'h00};
            walk_phase = cfnl_pkg::PH_ULEN_LO;
         end
         cfnl_pkg::PH_ULEN_LO: begin
            word_acc[7:0] = b;
            skip_left     = word_acc;
            if (skip_left == 0) close_entry();
            else walk_phase = cfnl_pkg::PH_USKIP;
         end
         cfnl_pkg::PH_USKIP: begin
            skip_left--;
            if (skip_left == 0) close_entry();
         end
         cfnl_pkg::PH_TAIL: begin
            if (skip_left == 2) begin
               word_acc = {b, 8'h00};
               skip_left--;
            end else if (skip_left == 1) begin
               word_acc[7:0] = b;
               find_name(word_acc);
            end else begin
               skip_left--;
            end
         end
         default: ;
      endcase
      file_pos = file_pos + 24'd1;
      if (lst) begin
         if (!name_done) give_result(cfnl_pkg::ST_TRUNCATED, '0, '0);
         clear_walk();
      end
   endtask

   // Offer one word after a random gap, none when calm, and hold it until it is taken.
   task automatic send_byte(input logic [7:0] b, input bit lst, input bit typed,
                            input name_result_type fixed);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= lst;
      do @(posedge clock); while (req_stall);
      parse_byte(b, lst);
      if (hit) name_q.push_back(typed ? fixed : hit_val);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < img.size(); i++)
         send_byte(img[i], i == img.size() - 1, 1'b0, '{default: '0});
   endtask

   // Build a class file image: header, pool of mixed entries, tail, stray bytes.
   task automatic make_file(input int count);
      int          tags[$];
      int          utf[$];
      int          cls[$];
      int          n, s, r, len, w, i;
      logic [7:0]  t;
      img.delete();
      repeat (8) img.push_back(8'($urandom));
      img.push_back(count[15:8]);
      img.push_back(count[7:0]);
      if (count > POOL) begin
         repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
         return;
      end
      n = (count == 0) ? 1 : count;
      tags.push_back(0);
      s = 1;
      while (s < n) begin
         r = $urandom_range(0, 99);
         if (r < 30) t = cfnl_pkg::TAG_UTF8;
         else if (r < 55) t = cfnl_pkg::TAG_CLASS;
         else if (r < 57) t = $urandom_range(0, 1) ? 8'($urandom_range(13, 255))
                                                   : 8'(2 * $urandom_range(0, 1));
         else begin
            case ($urandom_range(0, 10))
               0: t = cfnl_pkg::TAG_UTF8;       1: t = cfnl_pkg::TAG_INTEGER;
               2: t = cfnl_pkg::TAG_FLOAT;      3: t = cfnl_pkg::TAG_LONG;
               4: t = cfnl_pkg::TAG_DOUBLE;     5: t = cfnl_pkg::TAG_CLASS;
               6: t = cfnl_pkg::TAG_STRING;     7: t = cfnl_pkg::TAG_FIELDREF;
               8: t = cfnl_pkg::TAG_METHODREF;  9: t = cfnl_pkg::TAG_IMETHREF;
               default: t = cfnl_pkg::TAG_NAMETYPE;
            endcase
         end
         tags.push_back(t);
         if (t == cfnl_pkg::TAG_UTF8) utf.push_back(s);
         if (t == cfnl_pkg::TAG_CLASS) cls.push_back(s);
         if (t == cfnl_pkg::TAG_LONG || t == cfnl_pkg::TAG_DOUBLE) begin
            tags.push_back(0);
            s += 2;
         end else begin
            s++;
         end
      end
      i = 1;
      while (i < tags.size()) begin
         t = tags[i];
         img.push_back(t);
         case (t)
            cfnl_pkg::TAG_UTF8: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                 : $urandom_range(0, 6);
               img.push_back(len[15:8]);
               img.push_back(len[7:0]);
               repeat (len) img.push_back(8'($urandom));
            end
            cfnl_pkg::TAG_CLASS: begin
               w = (utf.size() > 0 && $urandom_range(0, 4) != 0)
                   ? utf[$urandom_range(0, utf.size() - 1)] : $urandom_range(0, n + 1);
               img.push_back(w[15:8]);
               img.push_back(w[7:0]);
            end
            cfnl_pkg::TAG_STRING: repeat (2) img.push_back(8'($urandom));
            cfnl_pkg::TAG_LONG, cfnl_pkg::TAG_DOUBLE: repeat (8) img.push_back(8'($urandom));
            default: repeat (4) img.push_back(8'($urandom));
         endcase
         i += (t == cfnl_pkg::TAG_LONG || t == cfnl_pkg::TAG_DOUBLE) ? 2 : 1;
      end
      // Access flags, then this_class.
      repeat (2) img.push_back(8'($urandom));
      if (cls.size() > 0 && $urandom_range(0, 6) != 0) w = cls[$urandom_range(0, cls.size() - 1)];
      else if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 65535);
      else w = $urandom_range(0, n + 1);
      img.push_back(w[15:8]);
      img.push_back(w[7:0]);
      repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
   endtask

   // Random files until the word count reaches the goal.
   task automatic run_random(input int goal);
      int r;
      while (bytes_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            img.delete();
            repeat ($urandom_range(1, 20)) img.push_back(8'($urandom));
         end else if (r < 13) begin
            make_file($urandom_range(POOL + 1, 65535));
         end else begin
            make_file(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 10));
         end
         if ($urandom_range(0, 9) == 0 && img.size() > 1)
            img = img[0:$urandom_range(0, img.size() - 2)];
         send_file();
      end
   endtask

   // New buffer limit, written only once the block has drained.
   task automatic set_limit(input logic [16:0] v);
      req_valid <= 1'b0;
      wait (name_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      buf_limit    = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: random stalls, checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = calm ? 0 : $urandom_range(0, 3);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
         if (name_q.size() == 0) begin
            report($sformatf("unexpected word status %0d", rsp_status));
         end else begin
            want = name_q.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_name_offset !== want.offset)
               report($sformatf("name_offset %0d, want %0d", rsp_name_offset, want.offset));
            if (rsp_name_length !== want.length)
               report($sformatf("name_length %0d, want %0d", rsp_name_length, want.length));
         end
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 3);
         rsp_stall  <= 1'b1;
      end
   end

   // Watchdog on cycles where nothing moves.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet == QUIET_MAX) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last      <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      reset         <= 1'b1;
      errors     = 0;
      bytes_sent = 0;
      calm       = 0;
      quiet      = 0;
      buf_limit  = 17'd2048;
      for (int i = 0; i < POOL; i++) begin
         pool_tag[i]  = '0;
         pool_word[i] = '0;
         pool_off[i]  = '0;
      end
      clear_walk();

      // Directed words: a lone final byte, an oversized pool, an unknown tag.
      dir_rows = '{
         '{8'h00, 1'b1, 1'b1, cfnl_pkg::ST_TRUNCATED, 24'd0, 16'd0},
         '{8'hCA, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFE, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hBA, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hBE, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h00, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h00, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h00, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h34, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h10, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h01, 1'b0, 1'b1, cfnl_pkg::ST_POOL_LARGE, 24'd0, 16'd0},
         '{8'hFF, 1'b1, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'hFF, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h00, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h02, 1'b0, 1'b0, cfnl_pkg::ST_OK, 24'd0, 16'd0},
         '{8'h00, 1'b1, 1'b1, cfnl_pkg::ST_UNKNOWN_TAG, 24'd0, 16'd0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                   '{dir_rows[i].status, dir_rows[i].offset, dir_rows[i].length});

      // Random files across several buffer limits, one stretch without idling.
      run_random(300);
      set_limit(17'd1);
      run_random(500);
      calm = 1;
      set_limit(17'd65536);
      run_random(700);
      calm = 0;
      set_limit(17'($urandom_range(1, 12)));
      run_random(1000);
      set_limit(17'($urandom_range(1, 65536)));
      run_random(1250);

      // One file whose pool count is just above what the table holds.
      set_limit(17'd2048);
      make_file(POOL + 1);
      send_file();

      req_valid <= 1'b0;
      wait (name_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
